// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL of the constant-weight encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside of reset.
`define CWE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define CWE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/cwe_pkg.sv =====
// Package with the sizes, register indexes and binomial rows of the constant-weight encoder.
`default_nettype none

package cwe_pkg;

  // Default sizes of the encoder.
  localparam int MaxLength = 64;
  localparam int MaxWeight = 16;

  // Largest weight that one binomial row covers.
  localparam int WeightCap = 32;
  // Index width of one binomial row (WeightCap + 1 entries).
  localparam int RowIdxW   = $clog2(WeightCap + 1);

  // Width of the rank and codeword ports and of the configuration data.
  localparam int WordW     = 64;
  localparam int CfgDataW  = 7;
  localparam int CfgIdxW   = 1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgCodeLength = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgWeight     = 1'b1;

  // One row of Pascal's triangle: entry k holds C(n, k).
  typedef logic [WeightCap:0][WordW-1:0] binom_row_t;

  // Builds row n of Pascal's triangle by repeated additions.
  function automatic binom_row_t binom_row(input int n);
    binom_row_t row;
    row = '0;
    row[0] = WordW'(1);
    for (int i = 0; i < n; i++) begin
      for (int k = WeightCap; k > 0; k--) begin
        row[k] = row[k] + row[k-1];
      end
    end
    return row;
  endfunction

endpackage

`default_nettype wire

// ===== sv/constant_weight_codeword_encoder_top.sv =====
// Top level of the constant-weight codeword encoder: a pipeline with one stage per position.
`default_nettype none

// Turns a one-based rank into a codeword of code_length bits with exactly weight ones,
// following the combinatorial number system from the top position down. The block takes
// one rank in every cycle while the output is not stalled. It has one entry stage, one
// compare-and-subtract stage for each codeword position, and one output stage that
// checks the range. Binomials are constants of each stage, so no table is built and the
// block is ready right after reset. A stall on the output holds the whole pipeline. A
// rank of zero, or one above C(code_length, weight), or a weight above MAX_WEIGHT gives
// out_of_range and a zero codeword. Write code_length and weight only while no beat is
// in flight.
module constant_weight_codeword_encoder_top #(
  parameter int MAX_LENGTH = cwe_pkg::MaxLength,
  parameter int MAX_WEIGHT = cwe_pkg::MaxWeight
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write port.
  input  wire logic                          cfg_we_i,
  input  wire logic [cwe_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [cwe_pkg::CfgDataW-1:0]  cfg_data_i,
  // Rank channel.
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [cwe_pkg::WordW-1:0]     rank_i,
  // Codeword channel.
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [cwe_pkg::WordW-1:0]          codeword_o,
  output logic                               out_of_range_o
);

  localparam int WordW = cwe_pkg::WordW;
  localparam int RowW  = cwe_pkg::RowIdxW;
  localparam int LenW  = $clog2(MAX_LENGTH + 1);
  localparam int KW    = $clog2(MAX_WEIGHT + 1);
  localparam int NStg  = MAX_LENGTH + 1;

  // Configuration registers.
  logic [6:0] code_length_q;
  logic [4:0] weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_length_q <= 7'd64;
      weight_q      <= 5'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cwe_pkg::CfgCodeLength: code_length_q <= cfg_data_i[6:0];
        cwe_pkg::CfgWeight:     weight_q      <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Pipeline registers, one set for each stage boundary.
  logic                  vld_q  [NStg];
  logic [WordW-1:0]      rem_q  [NStg];
  logic [KW-1:0]         k_q    [NStg];
  logic [LenW-1:0]       len_q  [NStg];
  logic [MAX_LENGTH-1:0] word_q [NStg];
  logic                  bad_q  [NStg];

  logic out_valid_q;
  logic [WordW-1:0] codeword_q;
  logic out_of_range_q;

  // The pipeline moves whenever the output register is free or being emptied.
  logic adv;
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Entry stage: saturate the length and flag ranks that can never be encoded.
  logic [LenW-1:0] len_d;
  logic [KW-1:0]   k_d;
  logic            bad_d;

  always_comb begin
    len_d = (32'(code_length_q) > MAX_LENGTH) ? LenW'(MAX_LENGTH) : LenW'(code_length_q);
    bad_d = (rank_i == '0) || (32'(weight_q) > MAX_WEIGHT);
    k_d   = (32'(weight_q) > MAX_WEIGHT) ? '0 : KW'(weight_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0]  <= rank_i;
      k_q[0]    <= k_d;
      len_q[0]  <= len_d;
      word_q[0] <= '0;
      bad_q[0]  <= bad_d;
    end
  end

  // One stage per position, highest position first.
  for (genvar s = 0; s < MAX_LENGTH; s++) begin : g_stage
    localparam int Pos = MAX_LENGTH - 1 - s;
    localparam cwe_pkg::binom_row_t Row = cwe_pkg::binom_row(Pos);
    localparam logic [MAX_LENGTH-1:0] PosBit = (MAX_LENGTH)'(1) << Pos;

    logic [WordW-1:0] coef;
    logic             take;

    // Set this bit when Pos is below the length, k is nonzero and rem exceeds C(Pos, k).
    always_comb begin
      coef = Row[RowW'(k_q[s])];
      take = (LenW'(Pos) < len_q[s]) && (k_q[s] != '0) && (rem_q[s] > coef);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (adv) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[s+1]  <= take ? (rem_q[s] - coef) : rem_q[s];
        k_q[s+1]    <= take ? (k_q[s] - KW'(1)) : k_q[s];
        word_q[s+1] <= take ? (word_q[s] | PosBit) : word_q[s];
        len_q[s+1]  <= len_q[s];
        bad_q[s+1]  <= bad_q[s];
      end
    end
  end

  // Output stage: a rank is in range exactly when no entry flag is set, the walk
  // placed every one and left a remainder of one.
  logic oor_d;
  assign oor_d = bad_q[MAX_LENGTH] || (k_q[MAX_LENGTH] != '0) ||
                 (rem_q[MAX_LENGTH] != WordW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_q[MAX_LENGTH];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      codeword_q     <= oor_d ? '0 : WordW'(word_q[MAX_LENGTH]);
      out_of_range_q <= oor_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign codeword_o     = codeword_q;
  assign out_of_range_o = out_of_range_q;

  // Checks on the pipeline and the result.
  `include "assert_macros.svh"

  `CWE_ASSERT(a_oor_zero_word, (out_valid_o && out_of_range_o) |-> (codeword_o == '0), "out of range beat carries a nonzero codeword")
  `CWE_ASSERT(a_last_stage_holds, (vld_q[MAX_LENGTH] && !adv) |=> (vld_q[MAX_LENGTH] && $stable(rem_q[MAX_LENGTH]) && $stable(word_q[MAX_LENGTH])), "last stage changed while the pipeline was held")
  `CWE_ASSERT(a_stall_when_full, (out_valid_o && out_stall_i) |=> ($stable(codeword_o) && $stable(out_of_range_o) && out_valid_o), "held result changed under stall")

endmodule

`default_nettype wire
